[hdl/vnorm_pkg.sv]
// Package for the vector normalizer: payload structs, controller/datapath
// command and status structs, widths and arithmetic constants.
// No dependencies.
package vnorm_pkg;

    localparam int VN_MAX_LEN = 16;      // default vector length limit

    localparam int ELEM_W  = 24;         // Q8.16 component
    localparam int OUT_W   = 32;         // Q1.30 component
    localparam int MAG_W   = 24;         // |element|
    localparam int SQ_W    = 47;         // |element|^2 <= 2^46
    localparam int SUM_W   = 51;         // Q19.32 square sum, saturating
    localparam int T_W     = 64;         // normalized sum
    localparam int ROOT_W  = 32;         // integer square root of T
    localparam int REM_W   = 33;         // divider remainder
    localparam int RECIP_W = 32;         // floor(2^61 / root)
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int K_W     = 5;          // normalize shift count, at most 30
    localparam int STEP_W  = 5;          // sqrt and divide iteration counter

    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd31;
    localparam logic [K_W-1:0]    H_BASE        = 5'd31;
    localparam logic [T_W-1:0]    SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
    localparam logic [REM_W-1:0]  DIV_REM_INIT  = 33'h0_2000_0000;   // 2^61 >> 32
    localparam logic [PROD_W:0]   ONE_Q30       = 57'h4000_0000;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_element;
        logic                    valid_norm;
        logic                    last_out;
    } t_out_item;

    typedef struct packed {
        logic capture;      // input transfer: latch square
        logic store;        // element kept: write store
        logic accumulate;   // add latched square to the sum
        logic load_t;       // copy new sum into the normalize register
        logic norm_step;    // T <<= 2, k++
        logic zero_path;    // zero sum: reciprocal 0
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic mul;          // |stored| * reciprocal
        logic emit;         // load output register
        logic last_out;
        logic clear;        // end of vector: clear the sum
    } t_dp_cmd;

    typedef struct packed {
        logic t_zero;       // sum is zero
        logic t_top;        // T in [2^60, 2^64)
        logic out_free;     // output register can take a result
    } t_dp_stat;

endpackage

[hdl/vnorm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vnorm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/vnorm_ctrl.sv]
// Vector normalizer controller: sequences load, normalize, square root,
// divide and emit phases. Depends on vnorm_pkg.
module vnorm_ctrl #(
    parameter int MAX_LEN = vnorm_pkg::VN_MAX_LEN,
    parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  vnorm_pkg::t_dp_stat i_stat,
    output vnorm_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]      o_waddr,
    output logic [AW-1:0]      o_raddr
);

    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ACC   = 9'b000000010,
        ST_NORM  = 9'b000000100,
        ST_SQRT  = 9'b000001000,
        ST_DINIT = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_RD    = 9'b001000000,
        ST_MUL   = 9'b010000000,
        ST_RND   = 9'b100000000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx, n_idx;
    logic [vnorm_pkg::STEP_W-1:0] r_iter, n_iter;
    logic                        r_last, n_last;
    logic                        accept;
    logic                        room;
    logic                        last_item;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign room       = (r_count < CW'(MAX_LEN));
    assign last_item  = ((r_idx + CW'(1)) == r_count);
    assign o_waddr    = r_count[AW-1:0];
    assign o_raddr    = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_iter  = r_iter;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.store   = room;
                    if (room) begin
                        n_count = r_count + CW'(1);
                    end
                    n_last  = i_in_last;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                if (r_last) begin
                    o_cmd.load_t = 1'b1;
                    n_state      = ST_NORM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NORM: begin
                if (i_stat.t_zero) begin
                    o_cmd.zero_path = 1'b1;
                    n_idx           = '0;
                    n_state         = ST_RD;
                end else if (i_stat.t_top) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_iter          = '0;
                    n_state         = ST_SQRT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == vnorm_pkg::STEP_LAST) begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_iter         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == vnorm_pkg::STEP_LAST) begin
                    n_idx   = '0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_MUL;   // store read in flight
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_RND;
            end
            ST_RND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.last_out = last_item;
                    if (last_item) begin
                        o_cmd.clear = 1'b1;
                        n_count     = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_iter  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_iter  <= n_iter;
            r_last  <= n_last;
        end
    end

endmodule

[hdl/vnorm_dp.sv]
// Vector normalizer datapath: element store, square sum, normalize shifter,
// iterative square root and divider, scaling multiplier, output register.
// Depends on vnorm_pkg and vnorm_ram.
module vnorm_dp #(
    parameter int MAX_LEN = vnorm_pkg::VN_MAX_LEN,
    parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vnorm_pkg::t_in_item   i_in_data,
    input  vnorm_pkg::t_dp_cmd    i_cmd,
    input  logic [AW-1:0]         i_waddr,
    input  logic [AW-1:0]         i_raddr,
    output vnorm_pkg::t_dp_stat   o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output vnorm_pkg::t_out_item  o_out_data
);

    localparam int ELEM_W  = vnorm_pkg::ELEM_W;
    localparam int MAG_W   = vnorm_pkg::MAG_W;
    localparam int SQ_W    = vnorm_pkg::SQ_W;
    localparam int SUM_W   = vnorm_pkg::SUM_W;
    localparam int T_W     = vnorm_pkg::T_W;
    localparam int ROOT_W  = vnorm_pkg::ROOT_W;
    localparam int REM_W   = vnorm_pkg::REM_W;
    localparam int RECIP_W = vnorm_pkg::RECIP_W;
    localparam int PROD_W  = vnorm_pkg::PROD_W;
    localparam int K_W     = vnorm_pkg::K_W;
    localparam int OUT_W   = vnorm_pkg::OUT_W;

    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [T_W-1:0]     r_t;
    logic [K_W-1:0]     r_k;
    logic [T_W-1:0]     r_x, r_root, r_bit;
    logic [REM_W-1:0]   r_rem;
    logic [RECIP_W-1:0] r_recip;
    logic               r_nz;
    logic [PROD_W-1:0]  r_prod;
    logic               r_neg;
    vnorm_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic [ELEM_W-1:0]  rd_data;
    logic [MAG_W-1:0]   in_mag, rd_mag;
    logic [2*MAG_W-1:0] sq_full;
    logic [SUM_W:0]     acc;
    logic [SUM_W-1:0]   sum_sat;
    logic [T_W:0]       sq_try;
    logic               sq_ge;
    logic [REM_W-1:0]   rem2;
    logic               div_ge;
    logic [K_W-1:0]     h;
    logic [PROD_W:0]    rounded, shifted;
    logic [OUT_W-1:0]   q_mag;

    vnorm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (i_waddr),
        .i_wdata (i_in_data.element),
        .i_raddr (i_raddr),
        .o_rdata (rd_data)
    );

    // load path
    assign in_mag  = i_in_data.element[ELEM_W-1] ? (~i_in_data.element + 1'b1)
                                                 : i_in_data.element;
    assign sq_full = in_mag * in_mag;
    assign acc     = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign sum_sat = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];

    // square root step
    assign sq_try  = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge   = ({1'b0, r_x} >= sq_try);

    // restoring divide step, dividend bits below the initial remainder are zero
    assign rem2    = {r_rem[REM_W-2:0], 1'b0};
    assign div_ge  = (rem2 >= {1'b0, r_root[ROOT_W-1:0]});

    // scale and round
    assign rd_mag  = rd_data[ELEM_W-1] ? (~rd_data + 1'b1) : rd_data;
    assign h       = vnorm_pkg::H_BASE - r_k;
    assign rounded = {1'b0, r_prod} + ((PROD_W + 1)'(1) << (h - 1'b1));
    assign shifted = rounded >> h;
    assign q_mag   = (shifted > vnorm_pkg::ONE_Q30) ? vnorm_pkg::ONE_Q30[OUT_W-1:0]
                                                    : shifted[OUT_W-1:0];

    assign o_stat.t_zero   = (r_t == '0);
    assign o_stat.t_top    = (r_t[T_W-1:T_W-4] != '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_sum <= '0;
            end else if (i_cmd.accumulate) begin
                r_sum <= sum_sat;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sq <= i_cmd.store ? sq_full[SQ_W-1:0] : '0;
        end
        if (i_cmd.load_t) begin
            r_t <= T_W'(sum_sat);
            r_k <= '0;
        end else if (i_cmd.norm_step) begin
            r_t <= r_t << 2;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.sqrt_init) begin
            r_x    <= r_t;
            r_root <= '0;
            r_bit  <= vnorm_pkg::SQRT_BIT_INIT;
        end else if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_x    <= r_x - sq_try[T_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.zero_path) begin
            r_recip <= '0;
            r_nz    <= 1'b0;
        end else if (i_cmd.div_init) begin
            r_rem   <= vnorm_pkg::DIV_REM_INIT;
            r_recip <= '0;
            r_nz    <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_rem   <= div_ge ? (rem2 - {1'b0, r_root[ROOT_W-1:0]}) : rem2;
            r_recip <= {r_recip[RECIP_W-2:0], div_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= rd_mag * r_recip;
            r_neg  <= rd_data[ELEM_W-1];
        end
        if (i_cmd.emit) begin
            r_out.unit_element <= r_neg ? (OUT_W'(0) - q_mag) : q_mag;
            r_out.valid_norm   <= r_nz;
            r_out.last_out     <= i_cmd.last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/vector_normalizer_unit.sv]
// Vector normalizer top level: ties controller and datapath together.
// Depends on vnorm_pkg, vnorm_ctrl, vnorm_dp (and vnorm_ram below it).
//
// Scales a vector, received one signed Q8.16 component per input transfer
// with the final component flagged by last, to unit length and returns the
// components as signed Q1.30 in arrival order, last_out on the final one.
// Up to MAX_LEN components are kept; further ones are dropped but a dropped
// last still closes the vector. A zero vector comes back as zeros with
// valid_norm low. Each component is loaded by its transfer, then the
// saturating square-sum add. After the last one the sum is normalized by
// one 2-bit shift per cycle (up to 30 shifts), then the integer square root
// and, after an init step, the reciprocal divide run at one bit per cycle
// each; a zero vector skips both. Each result then passes store read,
// multiply and round, waiting on any output stall, and the next store read
// starts only once it is emitted. Input ready is low from the transfer of a
// component until it is loaded, and from the last component until the final
// result sits in the output register, which keeps it while the next vector
// starts loading.
module vector_normalizer_unit #(
    parameter int MAX_LEN = vnorm_pkg::VN_MAX_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vnorm_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vnorm_pkg::t_out_item o_out_data
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    vnorm_pkg::t_dp_cmd  cmd;
    vnorm_pkg::t_dp_stat stat;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;

    vnorm_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_waddr    (waddr),
        .o_raddr    (raddr)
    );

    vnorm_dp #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_waddr     (waddr),
        .i_raddr     (raddr),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/vnorm_checker.sv]
// Port-level checks for vector_normalizer_unit, bound to the top level.
// Depends on vnorm_pkg and vector_normalizer_unit.
module vnorm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input vnorm_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input vnorm_pkg::t_out_item o_out_data
);

    // result held until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    // every component needs its accumulate cycle
    a_load_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken during accumulate");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.valid_norm |-> o_out_data.unit_element == 32'sd0)
        else $error("nonzero component from zero vector");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.unit_element <= 32'sh4000_0000) &&
                        (o_out_data.unit_element >= -32'sh4000_0000))
        else $error("component beyond unit range");

endmodule

bind vector_normalizer_unit vnorm_checker u_vnorm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
